// ===== rtl/fltw_pkg.sv =====
// Shared types, codes and the microcode program of the four-level page table walker.
// Used by fltw_sequencer, fltw_datapath and the top level; depends on nothing else.
package fltw_pkg;

  localparam int StepW = 4;
  localparam int EntryW = 64;

  typedef enum logic [1:0] {
    MODE_WRITE     = 2'd0,
    MODE_TRANSLATE = 2'd1,
    MODE_UNMAP     = 2'd2,
    MODE_NONE      = 2'd3
  } mode_e;

  // Jump conditions tested by a control word.
  typedef enum logic [1:0] {
    COND_NEVER = 2'd0,
    COND_WRITE = 2'd1,
    COND_MISS  = 2'd2,
    COND_LARGE = 2'd3
  } cond_e;

  typedef enum logic {
    ASEL_ROOT  = 1'b0,
    ASEL_ENTRY = 1'b1
  } asel_e;

  typedef enum logic [1:0] {
    LVL_4 = 2'd0,
    LVL_3 = 2'd1,
    LVL_2 = 2'd2,
    LVL_1 = 2'd3
  } lvl_e;

  typedef enum logic [2:0] {
    FIN_NONE  = 3'd0,
    FIN_WRITE = 3'd1,
    FIN_MISS  = 3'd2,
    FIN_LARGE = 3'd3,
    FIN_SMALL = 3'd4
  } fin_e;

  typedef struct packed {
    logic             rd;
    asel_e            asel;
    lvl_e             lvl;
    cond_e            cond;
    logic [StepW-1:0] target;
    fin_e             fin;
  } ctrl_t;

  typedef struct packed {
    logic write;
    logic miss;
    logic leaf_2m;
  } status_t;

  localparam logic [StepW-1:0] STEP_L4    = 4'd0;
  localparam logic [StepW-1:0] STEP_L3    = 4'd1;
  localparam logic [StepW-1:0] STEP_L2    = 4'd2;
  localparam logic [StepW-1:0] STEP_CHK   = 4'd3;
  localparam logic [StepW-1:0] STEP_L1    = 4'd4;
  localparam logic [StepW-1:0] STEP_SMALL = 4'd5;
  localparam logic [StepW-1:0] STEP_LARGE = 4'd6;
  localparam logic [StepW-1:0] STEP_MISS  = 4'd7;
  localparam logic [StepW-1:0] STEP_WRITE = 4'd8;

  // The walk program. Each step reads the entry chosen by the previous word, while
  // its jump condition looks at the word that the previous step fetched.
  function automatic ctrl_t ucode_word(logic [StepW-1:0] step);
    ctrl_t w;
    w = '{rd: 1'b0, asel: ASEL_ROOT, lvl: LVL_4, cond: COND_NEVER,
          target: STEP_MISS, fin: FIN_NONE};
    case (step)
      STEP_L4: begin
        w.rd = 1'b1;
        w.cond = COND_WRITE;
        w.target = STEP_WRITE;
      end
      STEP_L3: begin
        w.rd = 1'b1;
        w.asel = ASEL_ENTRY;
        w.lvl = LVL_3;
        w.cond = COND_MISS;
      end
      STEP_L2: begin
        w.rd = 1'b1;
        w.asel = ASEL_ENTRY;
        w.lvl = LVL_2;
        w.cond = COND_MISS;
      end
      // A present 2 MB directory entry is caught here, before the leaf read replaces it.
      STEP_CHK: begin
        w.cond = COND_LARGE;
        w.target = STEP_LARGE;
      end
      STEP_L1: begin
        w.rd = 1'b1;
        w.asel = ASEL_ENTRY;
        w.lvl = LVL_1;
        w.cond = COND_MISS;
      end
      STEP_SMALL: w.fin = FIN_SMALL;
      STEP_LARGE: w.fin = FIN_LARGE;
      STEP_WRITE: w.fin = FIN_WRITE;
      default:    w.fin = FIN_MISS;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/four_level_page_table_walker_unit.sv =====
// Four-level page table walker. Each of the four dependent entry reads takes one microcode
// step on the single memory read port. A table write, a miss at the top level, a 2 MB page,
// and a 4 KB page or a miss at the directory end the walk at successively later steps,
// and the result strobe is registered from the final step. The next start is taken in the
// strobe cycle, so a new walk begins only after the last one has ended; results cannot stall.
// After reset the table memory is cleared one word a cycle with busy held high throughout;
// the root frame register resets to zero and may be written meanwhile.
module four_level_page_table_walker_unit #(
  parameter int TABLE_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [63:0] address_i,
  input  logic [63:0] table_word_i,
  output logic        result_strobe_o,
  output logic [63:0] physical_address_o,
  output logic        hit_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [39:0] cfg_data_i
);
  import fltw_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    running;
  logic    clearing;
  logic    accept;

  assign busy = running || clearing;
  assign accept = start && !busy;
  assign cfg_ready_o = 1'b1;

  fltw_sequencer u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .status_i  (status),
    .ctrl_o    (ctrl),
    .running_o (running)
  );

  fltw_datapath #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .mode_i             (mode_i),
    .address_i          (address_i),
    .table_word_i       (table_word_i),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .ctrl_i             (ctrl),
    .status_o           (status),
    .clearing_o         (clearing),
    .physical_address_o (physical_address_o),
    .hit_o              (hit_o),
    .strobe_o           (result_strobe_o)
  );

`ifndef SYNTHESIS
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> running)
    else $error("accepted word did not start the walk");

  a_strobe_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !running)
    else $error("result shown while the walk is still running");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("two results in consecutive cycles");

  a_no_result_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !result_strobe_o && !running)
    else $error("walk activity during the clearing pass");
`endif

endmodule

// ===== rtl/fltw_sequencer.sv =====
// Microcode sequencer of the page table walker: step counter, program table and jumps.
// Depends on fltw_pkg for the control word, status and step codes.
module fltw_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  fltw_pkg::status_t status_i,
  output fltw_pkg::ctrl_t   ctrl_o,
  output logic            running_o
);
  import fltw_pkg::*;

  logic [StepW-1:0] pc_q, pc_d;
  logic             running_q, running_d;
  ctrl_t            word;
  logic             taken;

  assign word = ucode_word(pc_q);

  always_comb begin
    case (word.cond)
      COND_WRITE: taken = status_i.write;
      COND_MISS:  taken = status_i.miss;
      COND_LARGE: taken = status_i.leaf_2m;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    running_d = running_q;
    if (accept_i) begin
      pc_d = STEP_L4;
      running_d = 1'b1;
    end else if (running_q) begin
      if (word.fin != FIN_NONE) begin
        running_d = 1'b0;
      end else if (taken) begin
        pc_d = word.target;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_L4;
      running_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      running_q <= running_d;
    end
  end

  // Outside a walk the datapath sees a word that does nothing.
  always_comb begin
    ctrl_o = word;
    if (!running_q) begin
      ctrl_o.rd = 1'b0;
      ctrl_o.fin = FIN_NONE;
    end
  end

  assign running_o = running_q;

endmodule

// ===== rtl/fltw_datapath.sv =====
// Datapath of the page table walker: table memory with its clearing pass, entry and
// address registers, root frame register and result registers. Depends on fltw_pkg.
module fltw_datapath #(
  parameter int TABLE_WORDS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        mode_i,
  input  logic [63:0]       address_i,
  input  logic [63:0]       table_word_i,
  input  logic              cfg_we_i,
  input  logic [39:0]       cfg_data_i,
  input  fltw_pkg::ctrl_t   ctrl_i,
  output fltw_pkg::status_t status_o,
  output logic              clearing_o,
  output logic [63:0]       physical_address_o,
  output logic              hit_o,
  output logic              strobe_o
);
  import fltw_pkg::*;

  // The depth must be a power of two, so that word slots are the low address bits.
  localparam int AW = $clog2(TABLE_WORDS);
  localparam int BW = AW - 9;

  logic [EntryW-1:0] mem_q [TABLE_WORDS];
  logic [EntryW-1:0] rdata_q;
  logic [AW-1:0]     slot_q;
  logic [AW-1:0]     clr_cnt_q;
  logic              clearing_q;
  logic [BW-1:0]     root_q;
  mode_e             mode_q;
  logic [63:0]       addr_q;
  logic [63:0]       word_q;
  logic [63:0]       phys_q, phys_d;
  logic              hit_q, hit_d;
  logic              strobe_q;

  logic [8:0]        lvl_idx;
  logic [BW-1:0]     base_hi;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [EntryW-1:0] wdata;
  logic              fin;

  always_comb begin
    case (ctrl_i.lvl)
      LVL_4:   lvl_idx = addr_q[47:39];
      LVL_3:   lvl_idx = addr_q[38:30];
      LVL_2:   lvl_idx = addr_q[29:21];
      default: lvl_idx = addr_q[20:12];
    endcase
  end

  // A table base has its low twelve bits clear, so base plus index is a concatenation.
  assign base_hi = (ctrl_i.asel == ASEL_ROOT) ? root_q : rdata_q[AW+2:12];
  assign raddr = {base_hi, lvl_idx};
  assign fin = (ctrl_i.fin != FIN_NONE);

  always_comb begin
    we = 1'b0;
    waddr = slot_q;
    wdata = '0;
    phys_d = '0;
    hit_d = 1'b0;
    if (clearing_q) begin
      we = 1'b1;
      waddr = clr_cnt_q;
    end else begin
      case (ctrl_i.fin)
        FIN_WRITE: begin
          we = 1'b1;
          waddr = addr_q[AW-1:0];
          wdata = word_q;
        end
        FIN_LARGE: begin
          hit_d = 1'b1;
          if (mode_q == MODE_TRANSLATE) begin
            phys_d = {rdata_q[63:21], addr_q[20:0]};
          end else begin
            we = 1'b1;
          end
        end
        FIN_SMALL: begin
          if (mode_q == MODE_TRANSLATE) begin
            hit_d = rdata_q[0];
            phys_d = rdata_q[0] ? {rdata_q[63:12], addr_q[11:0]} : '0;
          end else begin
            // The leaf is zeroed whether or not it was present.
            we = 1'b1;
            hit_d = 1'b1;
          end
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      slot_q <= raddr;
    end
    if (accept_i) begin
      mode_q <= mode_e'(mode_i);
      addr_q <= address_i;
      word_q <= table_word_i;
    end
    if (fin) begin
      phys_q <= phys_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q <= '0;
      root_q <= '0;
      strobe_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(TABLE_WORDS - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (cfg_we_i) begin
        root_q <= cfg_data_i[BW-1:0];
      end
      strobe_q <= fin;
    end
  end

  assign status_o.write = (mode_q == MODE_WRITE);
  assign status_o.miss = !rdata_q[0] || (mode_q == MODE_NONE);
  // Only a present directory entry can map a 2 MB page.
  assign status_o.leaf_2m = rdata_q[0] && rdata_q[7];

  assign clearing_o = clearing_q;
  assign physical_address_o = phys_q;
  assign hit_o = hit_q;
  assign strobe_o = strobe_q;

endmodule
